/* rtl/stc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sterilizer cycle timer package
// Shared phase and action codes, register indexes, BCD digit limits and the
// configuration bundle passed from the register file to the sequencer.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned BcdW   = 16;
  localparam int unsigned DigitW = 4;

  // Largest legal value of each BCD digit
  localparam logic [DigitW-1:0] DigitMaxDec = 4'd9;
  localparam logic [DigitW-1:0] DigitMaxSec = 4'd5;

  // Reset value of both time registers: 10:00
  localparam logic [BcdW-1:0] CfgTimeReset = 16'h1000;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAT = 3'd1,
    PH_STER = 3'd2,
    PH_DRY  = 3'd3,
    PH_RAMP = 3'd4,
    PH_FIN  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_TEMP  = 2'd2,
    ACT_STOP  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_STERILE_TIME = 2'd0,
    CFG_DRY_TIME     = 2'd1,
    CFG_SOLIDS_MODE  = 2'd2
  } cfg_idx_e;

  // Configuration as seen by the sequencer; times are already digit-clamped
  typedef struct packed {
    logic [BcdW-1:0] sterile_time;
    logic [BcdW-1:0] dry_time;
    logic            solids;
  } cfg_t;

endpackage

/* rtl/stc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sterilizer cycle timer channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface stc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       door_open;

  modport source (output valid, output action, output door_open, input ready);
  modport sink   (input valid, input action, input door_open, output ready);
endinterface

interface stc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic [15:0] sterile_left_bcd;
  logic [15:0] dry_left_bcd;
  logic        heater_on;
  logic        vent_valve_on;
  logic        second_pulse;

  modport source (
    output valid, output phase, output sterile_left_bcd, output dry_left_bcd,
    output heater_on, output vent_valve_on, output second_pulse, input ready
  );
  modport sink (
    input valid, input phase, input sterile_left_bcd, input dry_left_bcd,
    input heater_on, input vent_valve_on, input second_pulse, output ready
  );
endinterface

interface stc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/stc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sterilizer cycle timer register file
// Holds the sterilization time, drying time and mode. Time digits are
// clamped to their BCD limits as they are written.
// ----------------------------------------------------------------------------
module stc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [1:0]    wr_index_i,
  input  logic [15:0]   wr_data_i,
  output stc_pkg::cfg_t cfg_o
);

  logic [15:0]   data_clamped;
  stc_pkg::cfg_t cfg_q;

  // Clamp each digit: minutes tens and units to 9, seconds tens to 5, units to 9
  always_comb begin
    data_clamped[15:12] = (wr_data_i[15:12] > stc_pkg::DigitMaxDec) ?
                          stc_pkg::DigitMaxDec : wr_data_i[15:12];
    data_clamped[11:8]  = (wr_data_i[11:8] > stc_pkg::DigitMaxDec) ?
                          stc_pkg::DigitMaxDec : wr_data_i[11:8];
    data_clamped[7:4]   = (wr_data_i[7:4] > stc_pkg::DigitMaxSec) ?
                          stc_pkg::DigitMaxSec : wr_data_i[7:4];
    data_clamped[3:0]   = (wr_data_i[3:0] > stc_pkg::DigitMaxDec) ?
                          stc_pkg::DigitMaxDec : wr_data_i[3:0];
  end

  assign wr_ready_o = 1'b1;

  // Write the addressed register on each beat; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sterile_time <= stc_pkg::CfgTimeReset;
      cfg_q.dry_time     <= stc_pkg::CfgTimeReset;
      cfg_q.solids       <= 1'b1;
    end else if (wr_valid_i) begin
      unique case (stc_pkg::cfg_idx_e'(wr_index_i))
        stc_pkg::CFG_STERILE_TIME: cfg_q.sterile_time <= data_clamped;
        stc_pkg::CFG_DRY_TIME:     cfg_q.dry_time     <= data_clamped;
        stc_pkg::CFG_SOLIDS_MODE:  cfg_q.solids       <= wr_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/stc_bcd_dec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sterilizer cycle timer BCD decrementer
// Subtracts one second from an MM:SS BCD value. Lower digits wrap to 9, 5
// and 9; minutes tens stops at zero.
// ----------------------------------------------------------------------------
module stc_bcd_dec (
  input  logic [15:0] val_i,
  output logic [15:0] val_o
);

  logic [3:0] mt, mu, st, su;
  logic       su_zero, st_zero, mu_zero;

  assign mt = val_i[15:12];
  assign mu = val_i[11:8];
  assign st = val_i[7:4];
  assign su = val_i[3:0];

  assign su_zero = (su == '0);
  assign st_zero = (st == '0);
  assign mu_zero = (mu == '0);

  // Ripple the borrow up through the four digits
  always_comb begin
    val_o[3:0]   = su_zero ? stc_pkg::DigitMaxDec : su - 4'd1;
    val_o[7:4]   = !su_zero ? st :
                   (st_zero ? stc_pkg::DigitMaxSec : st - 4'd1);
    val_o[11:8]  = !(su_zero && st_zero) ? mu :
                   (mu_zero ? stc_pkg::DigitMaxDec : mu - 4'd1);
    val_o[15:12] = (su_zero && st_zero && mu_zero && (mt != '0)) ? mt - 4'd1 : mt;
  end

endmodule

/* rtl/stc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sterilizer cycle timer sequencer
// Input register, phase and counter update, and result register. The cycle
// state advances when the item in the input register moves to the result.
// ----------------------------------------------------------------------------
module stc_core #(
  parameter int unsigned TICKS_PER_SECOND = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stc_pkg::cfg_t cfg_i,
  stc_in_if.sink        in_i,
  stc_out_if.source     out_o
);

  localparam int unsigned TickW = $clog2(TICKS_PER_SECOND + 1);

  // Input register
  logic              s1_valid_q;
  stc_pkg::action_e  s1_action_q;
  logic              s1_door_q;
  logic              s1_advance;

  // Cycle state
  stc_pkg::phase_e   phase_q, phase_d;
  logic [15:0]       ster_q, ster_d;
  logic [15:0]       dry_q, dry_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic              valve_q, valve_d;
  logic              pulse;
  logic [TickW:0]    tick_inc;
  logic [15:0]       ster_dec, dry_dec;

  // Result register
  logic              out_valid_q;
  stc_pkg::phase_e   res_phase_q;
  logic [15:0]       res_ster_q, res_dry_q;
  logic              res_heater_q, res_valve_q, res_pulse_q;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;

  stc_bcd_dec u_ster_dec (.val_i(ster_q), .val_o(ster_dec));
  stc_bcd_dec u_dry_dec  (.val_i(dry_q),  .val_o(dry_dec));

  assign tick_inc = {1'b0, tick_q} + (TickW + 1)'(1);

  // Next cycle state for the item in the input register
  always_comb begin
    phase_d = phase_q;
    ster_d  = ster_q;
    dry_d   = dry_q;
    tick_d  = tick_q;
    valve_d = valve_q;
    pulse   = 1'b0;
    unique case (s1_action_q)
      stc_pkg::ACT_TICK: begin
        if (phase_q == stc_pkg::PH_STER || phase_q == stc_pkg::PH_DRY) begin
          if (tick_inc >= (TickW + 1)'(TICKS_PER_SECOND)) begin
            tick_d = '0;
            pulse  = 1'b1;
            // Sterilizing at zero hands over to drying (solids) or ramp within the same second
            if (phase_q == stc_pkg::PH_STER) begin
              if (ster_q == '0) begin
                phase_d = cfg_i.solids ? stc_pkg::PH_DRY : stc_pkg::PH_RAMP;
              end else begin
                ster_d = ster_dec;
              end
            end
            if (phase_d == stc_pkg::PH_DRY) begin
              if (dry_q == '0) begin
                phase_d = stc_pkg::PH_FIN;
                valve_d = 1'b0;
              end else begin
                valve_d = 1'b1;
                dry_d   = dry_dec;
              end
            end
          end else begin
            tick_d = tick_inc[TickW-1:0];
          end
        end
      end
      stc_pkg::ACT_START: begin
        if (phase_q == stc_pkg::PH_IDLE) phase_d = stc_pkg::PH_HEAT;
      end
      stc_pkg::ACT_TEMP: begin
        if (phase_q == stc_pkg::PH_HEAT) begin
          ster_d  = cfg_i.sterile_time;
          dry_d   = cfg_i.dry_time;
          phase_d = stc_pkg::PH_STER;
        end
      end
      stc_pkg::ACT_STOP: begin
        phase_d = stc_pkg::PH_IDLE;
        valve_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Capture an input beat whenever the input register is free or moving on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_action_q <= stc_pkg::action_e'(in_i.action);
      s1_door_q   <= in_i.door_open;
    end
  end

  // Advance the cycle state as the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stc_pkg::PH_IDLE;
      ster_q  <= '0;
      dry_q   <= '0;
      tick_q  <= '0;
      valve_q <= 1'b0;
    end else if (s1_advance) begin
      phase_q <= phase_d;
      ster_q  <= ster_d;
      dry_q   <= dry_d;
      tick_q  <= tick_d;
      valve_q <= valve_d;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      res_phase_q  <= phase_d;
      res_ster_q   <= ster_d;
      res_dry_q    <= dry_d;
      res_heater_q <= (phase_d == stc_pkg::PH_HEAT || phase_d == stc_pkg::PH_STER) &&
                      !s1_door_q;
      res_valve_q  <= valve_d;
      res_pulse_q  <= pulse;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.phase            = res_phase_q;
  assign out_o.sterile_left_bcd = res_ster_q;
  assign out_o.dry_left_bcd     = res_dry_q;
  assign out_o.heater_on        = res_heater_q;
  assign out_o.vent_valve_on    = res_valve_q;
  assign out_o.second_pulse     = res_pulse_q;

endmodule

/* rtl/sterilizer_cycle_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sterilizer cycle timer
// Sequences a sterilizer cycle (idle, heating, sterilizing, drying or ramp,
// finished) with two BCD MM:SS down-counters stepped every
// TICKS_PER_SECOND timer ticks.
//
//   Channel  Dir  Beat contents
//   in_i     in   action, door_open
//   out_o    out  phase, sterile_left_bcd, dry_left_bcd, heater_on,
//                 vent_valve_on, second_pulse
//   cfg_i    in   index, data (register write, always ready)
//
// One item per clock while the result channel is not stalled; a result passes
// through the input register, then the result register.
// The phase and counter update is a single pass of logic between the two.
// Reset clears the phase to idle, both counters, the tick count and the
// valve latch; registers return to 10:00, 10:00 and solids mode.
// A stalled result holds in the result register while one more input beat
// is taken into the input register.
// ----------------------------------------------------------------------------
module sterilizer_cycle_timer #(
  parameter int unsigned TICKS_PER_SECOND = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stc_in_if.sink    in_i,
  stc_out_if.source out_o,
  stc_cfg_if.sink   cfg_i
);

  stc_pkg::cfg_t cfg;

  stc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  stc_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

/* rtl/stc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sterilizer cycle timer port checker
// Watches the result channel for stall stability and for output
// combinations that the cycle sequence cannot produce.
// ----------------------------------------------------------------------------
module stc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  phase_i,
  input logic [15:0] sterile_left_i,
  input logic [15:0] dry_left_i,
  input logic        heater_on_i,
  input logic        vent_valve_on_i,
  input logic        second_pulse_i
);

  // A stalled result beat keeps its phase, both counters and the vent valve
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(phase_i) &&
      $stable(sterile_left_i) && $stable(dry_left_i) && $stable(vent_valve_on_i))
    else $error("stalled result beat changed");

  // Heater only drives in heating or sterilizing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && heater_on_i |->
      phase_i == stc_pkg::PH_HEAT || phase_i == stc_pkg::PH_STER)
    else $error("heater on outside heating or sterilizing");

  // The vent latch is set only while drying and clears when drying ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && vent_valve_on_i |-> phase_i == stc_pkg::PH_DRY)
    else $error("vent valve on outside drying");

  // A counted second can only leave the block in a timed or later phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && second_pulse_i |->
      phase_i != stc_pkg::PH_IDLE && phase_i != stc_pkg::PH_HEAT)
    else $error("second pulse in idle or heating");

endmodule

bind sterilizer_cycle_timer stc_checker u_stc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .phase_i         (out_o.phase),
  .sterile_left_i  (out_o.sterile_left_bcd),
  .dry_left_i      (out_o.dry_left_bcd),
  .heater_on_i     (out_o.heater_on),
  .vent_valve_on_i (out_o.vent_valve_on),
  .second_pulse_i  (out_o.second_pulse)
);

/* sim/tb_sterilizer_cycle_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sterilizer cycle timer testbench
// Drives action beats into the sequencer and checks every result beat against
// a beat-by-beat predictor of the phase, both BCD counters, the heater, the
// vent latch and the second pulse. Register settings change only while the
// sequencer is drained. Sender gaps and receiver stalls come in random bursts.
// ----------------------------------------------------------------------------
module tb_sterilizer_cycle_timer;

  localparam int unsigned TicksPerSecond = 20;
  localparam int          QuietLimit     = 2000;
  localparam int          ItemTarget     = 660;
  localparam int          MaxCycleTicks  = 100;
  localparam int          DrainCycles    = 4;
  localparam logic [1:0]  CfgIdxUnused   = 2'd3;

  typedef struct packed {
    stc_pkg::action_e act;
    logic             door;
  } beat_t;

  typedef struct packed {
    stc_pkg::phase_e phase;
    logic [15:0]     sterile_left;
    logic [15:0]     dry_left;
    logic            heater;
    logic            vent;
    logic            pulse;
  } status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // TB-side drivers, known from time zero
  logic        in_valid  = 1'b0;
  logic [1:0]  in_action = stc_pkg::ACT_TICK;
  logic        in_door   = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = stc_pkg::CFG_STERILE_TIME;
  logic [15:0] cfg_data  = '0;

  stc_in_if  in_if ();
  stc_out_if out_if ();
  stc_cfg_if cfg_if ();

  assign in_if.valid     = in_valid;
  assign in_if.action    = in_action;
  assign in_if.door_open = in_door;
  assign out_if.ready    = out_ready;
  assign cfg_if.valid    = cfg_valid;
  assign cfg_if.index    = cfg_index;
  assign cfg_if.data     = cfg_data;

  sterilizer_cycle_timer #(
    .TICKS_PER_SECOND(TicksPerSecond)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // Register shadows
  logic [15:0] set_sterile = stc_pkg::CfgTimeReset;
  logic [15:0] set_dry     = stc_pkg::CfgTimeReset;
  logic        set_solids  = 1'b1;

  // Predicted sequencer state
  stc_pkg::phase_e ph_now     = stc_pkg::PH_IDLE;
  logic [4:0]      tick_cnt   = '0;
  logic [15:0]     ster_left  = '0;
  logic [15:0]     dry_left   = '0;
  logic            vent_latch = 1'b0;

  beat_t   pending_q[$];
  status_t status_q[$];
  beat_t   drv_beat;
  status_t want;
  int      items_left   = 0;
  int      queued_total = 0;
  int      err_cnt      = 0;
  int      send_hold    = 0;
  int      stall_hold   = 0;
  int      quiet_cycles = 0;
  bit      idle_on      = 1'b0;

  // Clamp each digit of a configured time to its legal maximum
  function automatic logic [15:0] sat_digits(logic [15:0] v);
    logic [15:0] r;
    r = v;
    if (r[15:12] > stc_pkg::DigitMaxDec) r[15:12] = stc_pkg::DigitMaxDec;
    if (r[11:8] > stc_pkg::DigitMaxDec) r[11:8] = stc_pkg::DigitMaxDec;
    if (r[7:4] > stc_pkg::DigitMaxSec) r[7:4] = stc_pkg::DigitMaxSec;
    if (r[3:0] > stc_pkg::DigitMaxDec) r[3:0] = stc_pkg::DigitMaxDec;
    return r;
  endfunction

  // Take one second off an MM:SS value; minutes tens stop at zero
  function automatic logic [15:0] bcd_dec_second(logic [15:0] v);
    logic [15:0] r;
    r = v;
    if (r[3:0] != 4'd0) begin
      r[3:0] = r[3:0] - 4'd1;
    end else begin
      r[3:0] = stc_pkg::DigitMaxDec;
      if (r[7:4] != 4'd0) begin
        r[7:4] = r[7:4] - 4'd1;
      end else begin
        r[7:4] = stc_pkg::DigitMaxSec;
        if (r[11:8] != 4'd0) begin
          r[11:8] = r[11:8] - 4'd1;
        end else begin
          r[11:8] = stc_pkg::DigitMaxDec;
          if (r[15:12] != 4'd0) r[15:12] = r[15:12] - 4'd1;
        end
      end
    end
    return r;
  endfunction

  function automatic int secs_of(logic [15:0] v);
    return v[15:12] * 600 + v[11:8] * 60 + v[7:4] * 10 + v[3:0];
  endfunction

  // Advance the predicted sequencer by one beat and return its status
  function automatic status_t advance_cycle(stc_pkg::action_e act, logic door);
    status_t r;
    logic    pulse;
    pulse = 1'b0;
    case (act)
      stc_pkg::ACT_TICK: begin
        if (ph_now == stc_pkg::PH_STER || ph_now == stc_pkg::PH_DRY) begin
          tick_cnt = tick_cnt + 5'd1;
          if (tick_cnt >= TicksPerSecond) begin
            tick_cnt = '0;
            pulse    = 1'b1;
            if (ph_now == stc_pkg::PH_STER) begin
              if (ster_left == '0) ph_now = set_solids ? stc_pkg::PH_DRY : stc_pkg::PH_RAMP;
              else ster_left = bcd_dec_second(ster_left);
            end
            // drying may start in the very second sterilizing ended
            if (ph_now == stc_pkg::PH_DRY) begin
              if (dry_left == '0) begin
                ph_now     = stc_pkg::PH_FIN;
                vent_latch = 1'b0;
              end else begin
                vent_latch = 1'b1;
                dry_left   = bcd_dec_second(dry_left);
              end
            end
          end
        end
      end
      stc_pkg::ACT_START: begin
        if (ph_now == stc_pkg::PH_IDLE) ph_now = stc_pkg::PH_HEAT;
      end
      stc_pkg::ACT_TEMP: begin
        if (ph_now == stc_pkg::PH_HEAT) begin
          ster_left = sat_digits(set_sterile);
          dry_left  = sat_digits(set_dry);
          ph_now    = stc_pkg::PH_STER;
        end
      end
      default: begin
        ph_now     = stc_pkg::PH_IDLE;
        vent_latch = 1'b0;
      end
    endcase
    r.phase        = ph_now;
    r.sterile_left = ster_left;
    r.dry_left     = dry_left;
    r.heater       = (ph_now == stc_pkg::PH_HEAT || ph_now == stc_pkg::PH_STER) && !door;
    r.vent         = vent_latch;
    r.pulse        = pulse;
    return r;
  endfunction

  task automatic push_beat(stc_pkg::action_e act, logic door);
    pending_q.push_back('{act: act, door: door});
    items_left++;
    queued_total++;
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 3)) begin
      push_beat(stc_pkg::action_e'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)));
    end
  endtask

  // One sterilizer run: start, temperature reached, ticks, stop; sometimes
  // broken by stray beats, a missing temperature beat or an early stop
  task automatic queue_cycle();
    int need;
    int n_ticks;
    int cut;
    if ($urandom_range(0, 4) == 0) queue_noise();
    push_beat(stc_pkg::ACT_START, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 7) != 0) push_beat(stc_pkg::ACT_TEMP, 1'($urandom_range(0, 1)));
    need = secs_of(sat_digits(set_sterile)) + 2;
    if (set_solids) need = need + secs_of(sat_digits(set_dry)) + 1;
    need = need * TicksPerSecond;
    n_ticks = (need <= MaxCycleTicks) ? need : $urandom_range(1, MaxCycleTicks);
    cut = $urandom_range(0, n_ticks);
    for (int i = 0; i < n_ticks; i++) begin
      if (i == cut && $urandom_range(0, 3) == 0) queue_noise();
      push_beat(stc_pkg::ACT_TICK, 1'($urandom_range(0, 1)));
    end
    push_beat(stc_pkg::ACT_STOP, 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      stc_pkg::CFG_STERILE_TIME: set_sterile = val;
      stc_pkg::CFG_DRY_TIME:     set_dry     = val;
      stc_pkg::CFG_SOLIDS_MODE:  set_solids  = val[0];
      default: ;
    endcase
  endtask

  // Hold until every beat is taken and every result has come back
  task automatic wait_idle();
    while (items_left != 0 || status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_setting(logic [15:0] st, logic [15:0] dt, logic sol, int runs);
    write_reg(stc_pkg::CFG_STERILE_TIME, st);
    write_reg(stc_pkg::CFG_DRY_TIME, dt);
    write_reg(stc_pkg::CFG_SOLIDS_MODE, {15'd0, sol});
    idle_on = ($urandom_range(0, 3) != 0);
    repeat (runs) queue_cycle();
    wait_idle();
  endtask

  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'h9959;
      2:       return 16'hFFFF;
      3:       return 16'h1000;
      4:       return 16'h0100;
      5:       return 16'($urandom);
      default: return {8'h00, 4'($urandom_range(0, 3) == 0), 4'($urandom_range(0, 3))};
    endcase
  endfunction

  task automatic report_diff(string field, logic [15:0] exp_v, logic [15:0] got_v);
    err_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
  endtask

  // Driver: predict each accepted beat, then present the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_if.ready) begin
        status_q.push_back(advance_cycle(stc_pkg::action_e'(in_action), in_door));
        items_left--;
      end
      if (!in_valid || in_if.ready) begin
        if (send_hold != 0) begin
          send_hold--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          drv_beat = pending_q.pop_front();
          in_valid  <= 1'b1;
          in_action <= drv_beat.act;
          in_door   <= drv_beat.door;
          if (idle_on && $urandom_range(0, 9) == 0) send_hold = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_diff("unexpected beat, phase", '0, 16'(out_if.phase));
        end else begin
          want = status_q.pop_front();
          if (out_if.phase !== want.phase)
            report_diff("phase", 16'(want.phase), 16'(out_if.phase));
          if (out_if.sterile_left_bcd !== want.sterile_left)
            report_diff("sterile_left_bcd", want.sterile_left, out_if.sterile_left_bcd);
          if (out_if.dry_left_bcd !== want.dry_left)
            report_diff("dry_left_bcd", want.dry_left, out_if.dry_left_bcd);
          if (out_if.heater_on !== want.heater)
            report_diff("heater_on", 16'(want.heater), 16'(out_if.heater_on));
          if (out_if.vent_valve_on !== want.vent)
            report_diff("vent_valve_on", 16'(want.vent), 16'(out_if.vent_valve_on));
          if (out_if.second_pulse !== want.pulse)
            report_diff("second_pulse", 16'(want.pulse), 16'(out_if.second_pulse));
        end
      end
      if (stall_hold != 0) begin
        stall_hold--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_hold = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run when no channel moves a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_if.ready) || (out_if.valid && out_ready) ||
          (cfg_valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: ignored beats in idle, heating and sterilizing, stops
    idle_on = 1'b1;
    push_beat(stc_pkg::ACT_TICK, 1'b0);
    push_beat(stc_pkg::ACT_TEMP, 1'b1);
    push_beat(stc_pkg::ACT_STOP, 1'b0);
    push_beat(stc_pkg::ACT_START, 1'b1);
    push_beat(stc_pkg::ACT_START, 1'b0);
    push_beat(stc_pkg::ACT_TICK, 1'b1);
    push_beat(stc_pkg::ACT_TEMP, 1'b1);
    push_beat(stc_pkg::ACT_TEMP, 1'b0);
    push_beat(stc_pkg::ACT_STOP, 1'b1);
    push_beat(stc_pkg::ACT_START, 1'b0);
    push_beat(stc_pkg::ACT_STOP, 1'b0);
    wait_idle();

    // Oversized digits clamp on load; unused register index is dropped
    write_reg(stc_pkg::CFG_STERILE_TIME, 16'hFFFF);
    write_reg(stc_pkg::CFG_DRY_TIME, 16'hFAFA);
    write_reg(stc_pkg::CFG_SOLIDS_MODE, 16'd0);
    write_reg(CfgIdxUnused, 16'hFFFF);
    push_beat(stc_pkg::ACT_START, 1'b0);
    push_beat(stc_pkg::ACT_TEMP, 1'b0);
    push_beat(stc_pkg::ACT_STOP, 1'b1);
    wait_idle();

    // Fixed settings: zero times, liquids ramp, borrows, largest time
    run_setting(16'h0000, 16'h0000, 1'b1, 2);
    run_setting(16'h0001, 16'h0002, 1'b0, 2);
    run_setting(16'h0000, 16'h0003, 1'b1, 2);
    run_setting(16'h1000, 16'h0010, 1'b1, 1);
    run_setting(16'h0100, 16'h1000, 1'b1, 1);
    run_setting(16'h9959, 16'h9959, 1'b0, 1);

    // Random settings until the item budget is spent
    while (queued_total < ItemTarget) begin
      run_setting(pick_time(), pick_time(), 1'($urandom_range(0, 1)), $urandom_range(1, 3));
    end

    // Closing stretch without gaps or stalls
    write_reg(stc_pkg::CFG_STERILE_TIME, 16'h0001);
    write_reg(stc_pkg::CFG_DRY_TIME, 16'h0001);
    write_reg(stc_pkg::CFG_SOLIDS_MODE, 16'd1);
    idle_on = 1'b0;
    queue_cycle();
    queue_cycle();
    wait_idle();
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
